/* hw/rtl/kidi_pkg.sv */
`default_nettype none
package kidi_pkg;

  // Sizing
  localparam int MAX_POINTS = 1024;
  localparam int NEIGHBOURS = 15;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W   = 24;
  localparam int SMOOTH_W  = 20;
  localparam int ADDR_W    = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int NB_CNT_W  = $clog2(NEIGHBOURS + 1);
  localparam int NB_IDX_W  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int D2_W      = 2 * DIFF_W;
  // weight = floor(2^48 / (d2 + smoothing)), at most 2^48
  localparam int WEIGHT_SH = 48;
  localparam int W_W       = WEIGHT_SH + 1;
  localparam int TOT_W     = W_W + NB_CNT_W;
  localparam int ACC_W     = W_W + COORD_W + NB_CNT_W;
  localparam int MAG_W     = ACC_W - 1;
  localparam int PROD_W    = W_W;
  localparam int W_LO_W    = COORD_W;
  localparam int DIV_W     = (TOT_W > D2_W) ? TOT_W : D2_W;
  localparam int SH_W      = W_W;
  localparam int IT_W      = $clog2(SH_W + 1);

  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(16384);

  // d2 below 1e-6 in real units counts as a coincident point
  localparam longint unsigned HIT_LIMIT_L =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
  localparam logic [D2_W-1:0] HIT_LIMIT = D2_W'(HIT_LIMIT_L);

  // Opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;

  typedef enum logic [2:0] {
    ST_INTERP  = 3'd0,
    ST_HIT     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_STORED  = 3'd3,
    ST_DROPPED = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    VAL_ZERO = 2'd0,
    VAL_HIT  = 2'd1,
    VAL_QUOT = 2'd2
  } val_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     clear;
    logic     query_start;
    logic     acc_clear;
    logic     div_w_start;
    logic     mul_lo;
    logic     acc_lo;
    logic     mul_hi;
    logic     acc_hi;
    logic     div_f_start;
    logic     val_we;
    val_sel_t val_sel;
  } kidi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_busy;
    logic hit;
    logic div_busy;
    logic last_nb;
    logic total_zero;
  } kidi_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/kidi_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Dividend is rem_init followed by the top iters bits of sh_init.
module kidi_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [kidi_pkg::DIV_W-1:0]   rem_init,
  input  wire logic [kidi_pkg::SH_W-1:0]    sh_init,
  input  wire logic [kidi_pkg::DIV_W-1:0]   divisor,
  input  wire logic [kidi_pkg::IT_W-1:0]    iters,
  output logic                              busy,
  output logic [kidi_pkg::SH_W-1:0]         quot
);

  logic [kidi_pkg::DIV_W-1:0] rem;
  logic [kidi_pkg::DIV_W-1:0] dvs;
  logic [kidi_pkg::SH_W-1:0]  sh;
  logic [kidi_pkg::IT_W-1:0]  cnt;
  logic [kidi_pkg::DIV_W:0]   trial;
  logic [kidi_pkg::DIV_W:0]   diff;
  logic                       fits;

  // Trial subtract
  always_comb begin
    trial = {rem, sh[kidi_pkg::SH_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
      rem  <= rem_init;
      sh   <= sh_init;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[kidi_pkg::DIV_W-1:0] : trial[kidi_pkg::DIV_W-1:0];
      sh   <= sh << 1;
      quot <= {quot[kidi_pkg::SH_W-2:0], fits};
      cnt  <= cnt - kidi_pkg::IT_W'(1);
      busy <= (cnt != kidi_pkg::IT_W'(1));
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/kidi_ctrl.sv */
`default_nettype none
// Sequencer: decode, scan, per-neighbor weight loop, final divide.
module kidi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          opcode,
  input  wire kidi_pkg::kidi_stat_t stat,
  output kidi_pkg::kidi_cmd_t      cmd,
  output logic                     busy,
  output logic                     done,
  output logic [2:0]               status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WSTART, S_WWAIT, S_MLO, S_ALO, S_MHI, S_AHI,
    S_FSTART, S_FWAIT
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.val_sel = kidi_pkg::VAL_ZERO;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            kidi_pkg::OP_LOAD: begin
              cmd.load   = 1'b1;
              cmd.val_we = 1'b1;
            end
            kidi_pkg::OP_CLEAR: begin
              cmd.clear  = 1'b1;
              cmd.val_we = 1'b1;
            end
            default: begin
              if (stat.count_zero) cmd.val_we = 1'b1;
              else cmd.query_start = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          if (stat.hit) begin
            cmd.val_we  = 1'b1;
            cmd.val_sel = kidi_pkg::VAL_HIT;
          end else begin
            cmd.acc_clear = 1'b1;
          end
        end
      end
      S_WSTART: cmd.div_w_start = 1'b1;
      S_MLO:    cmd.mul_lo = 1'b1;
      S_ALO:    cmd.acc_lo = 1'b1;
      S_MHI:    cmd.mul_hi = 1'b1;
      S_AHI:    cmd.acc_hi = 1'b1;
      S_FSTART: begin
        if (stat.total_zero) cmd.val_we = 1'b1;
        else cmd.div_f_start = 1'b1;
      end
      S_FWAIT: begin
        if (!stat.div_busy) begin
          cmd.val_we  = 1'b1;
          cmd.val_sel = kidi_pkg::VAL_QUOT;
        end
      end
      default: cmd = '0;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      status <= kidi_pkg::ST_INTERP;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (opcode)
              kidi_pkg::OP_LOAD: begin
                done   <= 1'b1;
                status <= stat.count_full ? kidi_pkg::ST_DROPPED : kidi_pkg::ST_STORED;
              end
              kidi_pkg::OP_CLEAR: begin
                done   <= 1'b1;
                status <= kidi_pkg::ST_CLEARED;
              end
              default: begin
                if (stat.count_zero) begin
                  done   <= 1'b1;
                  status <= kidi_pkg::ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stat.scan_busy) begin
            if (stat.hit) begin
              done   <= 1'b1;
              status <= kidi_pkg::ST_HIT;
              state  <= S_IDLE;
            end else begin
              state <= S_WSTART;
            end
          end
        end
        S_WSTART: state <= S_WWAIT;
        S_WWAIT:  if (!stat.div_busy) state <= S_MLO;
        S_MLO:    state <= S_ALO;
        S_ALO:    state <= S_MHI;
        S_MHI:    state <= S_AHI;
        S_AHI:    state <= stat.last_nb ? S_FSTART : S_WSTART;
        S_FSTART: begin
          if (stat.total_zero) begin
            done   <= 1'b1;
            status <= kidi_pkg::ST_INTERP;
            state  <= S_IDLE;
          end else begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
          if (!stat.div_busy) begin
            done   <= 1'b1;
            status <= kidi_pkg::ST_INTERP;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/kidi_dp.sv */
`default_nettype none
// Datapath: point store, distance pipeline, sorted neighbor list,
// weight accumulation and the shared divider.
module kidi_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire kidi_pkg::kidi_cmd_t                 cmd,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] pos_x,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] pos_y,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] height,
  input  wire logic                                cfg_we,
  input  wire logic [kidi_pkg::SMOOTH_W-1:0]       cfg_wdata,
  output kidi_pkg::kidi_stat_t                     stat,
  output logic signed [kidi_pkg::COORD_W-1:0]      value
);

  localparam int CW = kidi_pkg::COORD_W;
  localparam int NB = kidi_pkg::NEIGHBOURS;

  logic [kidi_pkg::SMOOTH_W-1:0] smoothing;
  logic [kidi_pkg::CNT_W-1:0]    point_count;
  logic [3*CW-1:0]               mem [kidi_pkg::MAX_POINTS];
  logic [3*CW-1:0]               rd_data;

  logic signed [CW-1:0]          qx, qy;
  logic                          issuing;
  logic [kidi_pkg::ADDR_W-1:0]   scan_addr;
  logic                          s1_v, s2_v, s3_v, s4_v;
  logic [kidi_pkg::DIFF_W-1:0]   s2_ax, s2_ay;
  logic [CW-1:0]                 s2_z, s3_z, s4_z;
  logic [kidi_pkg::D2_W-1:0]     s3_sx, s3_sy, s4_d2;
  logic signed [kidi_pkg::DIFF_W-1:0] dx, dy;

  logic [kidi_pkg::D2_W-1:0]     nb_d2 [NB];
  logic [CW-1:0]                 nb_z  [NB];
  logic [kidi_pkg::D2_W-1:0]     nb_d2_next [NB];
  logic [CW-1:0]                 nb_z_next  [NB];
  logic [NB-1:0]                 gt;
  logic [kidi_pkg::NB_CNT_W-1:0] nb_cnt;
  logic [kidi_pkg::NB_IDX_W-1:0] nb_sel;

  logic [kidi_pkg::D2_W-1:0]     sel_d2;
  logic [CW-1:0]                 sel_z;
  logic [CW-1:0]                 az;
  logic [kidi_pkg::PROD_W-1:0]   prod;
  logic signed [kidi_pkg::ACC_W-1:0] acc;
  logic signed [kidi_pkg::ACC_W-1:0] acc_abs;
  logic signed [kidi_pkg::ACC_W-1:0] addend;
  logic [kidi_pkg::TOT_W-1:0]    total;
  logic                          res_neg;
  logic [kidi_pkg::MAG_W-1:0]    mag;

  logic                          div_start, div_busy;
  logic [kidi_pkg::DIV_W-1:0]    div_rem_init, div_divisor;
  logic [kidi_pkg::SH_W-1:0]     div_sh_init, div_q;
  logic [kidi_pkg::IT_W-1:0]     div_iters;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) smoothing <= kidi_pkg::SMOOTH_RESET;
    else if (cfg_we) smoothing <= cfg_wdata;
  end

  // Point count
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.clear) begin
      point_count <= '0;
    end else if (cmd.load && !stat.count_full) begin
      point_count <= point_count + kidi_pkg::CNT_W'(1);
    end
  end

  // Point store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && !stat.count_full) begin
      mem[point_count[kidi_pkg::ADDR_W-1:0]] <= {pos_x, pos_y, height};
    end
    rd_data <= mem[scan_addr];
  end

  // Scan address generator
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      scan_addr <= '0;
    end else if (cmd.query_start) begin
      issuing   <= 1'b1;
      scan_addr <= '0;
    end else if (issuing) begin
      if (kidi_pkg::CNT_W'(scan_addr) == point_count - kidi_pkg::CNT_W'(1)) begin
        issuing <= 1'b0;
      end else begin
        scan_addr <= scan_addr + kidi_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx <= pos_x;
      qy <= pos_y;
    end
  end

  // Distance pipeline: difference, square, sum
  always_comb begin
    dx = kidi_pkg::DIFF_W'(signed'(rd_data[3*CW-1:2*CW])) - kidi_pkg::DIFF_W'(qx);
    dy = kidi_pkg::DIFF_W'(signed'(rd_data[2*CW-1:CW])) - kidi_pkg::DIFF_W'(qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= issuing;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_ax <= dx[kidi_pkg::DIFF_W-1] ? kidi_pkg::DIFF_W'(-dx) : kidi_pkg::DIFF_W'(dx);
    s2_ay <= dy[kidi_pkg::DIFF_W-1] ? kidi_pkg::DIFF_W'(-dy) : kidi_pkg::DIFF_W'(dy);
    s2_z  <= rd_data[CW-1:0];
    s3_sx <= kidi_pkg::D2_W'(s2_ax) * kidi_pkg::D2_W'(s2_ax);
    s3_sy <= kidi_pkg::D2_W'(s2_ay) * kidi_pkg::D2_W'(s2_ay);
    s3_z  <= s2_z;
    s4_d2 <= s3_sx + s3_sy;
    s4_z  <= s3_z;
  end

  // Sorted insertion: a slot moves down when its d2 is strictly larger,
  // so equal distances keep the earlier point first
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      gt[i] = (kidi_pkg::NB_CNT_W'(i) >= nb_cnt) || (nb_d2[i] > s4_d2);
    end
    for (int i = 0; i < NB; i++) begin
      nb_d2_next[i] = nb_d2[i];
      nb_z_next[i]  = nb_z[i];
      if (gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          nb_d2_next[i] = nb_d2[(i > 0) ? i - 1 : 0];
          nb_z_next[i]  = nb_z[(i > 0) ? i - 1 : 0];
        end else begin
          nb_d2_next[i] = s4_d2;
          nb_z_next[i]  = s4_z;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v && gt[NB-1]) begin
      for (int i = 0; i < NB; i++) begin
        nb_d2[i] <= nb_d2_next[i];
        nb_z[i]  <= nb_z_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_cnt <= '0;
    end else if (cmd.query_start) begin
      nb_cnt <= '0;
    end else if (s4_v && nb_cnt != kidi_pkg::NB_CNT_W'(NB)) begin
      nb_cnt <= nb_cnt + kidi_pkg::NB_CNT_W'(1);
    end
  end

  // Neighbor being weighted
  always_comb begin
    sel_d2 = nb_d2[nb_sel];
    sel_z  = nb_z[nb_sel];
    az     = sel_z[CW-1] ? CW'(-sel_z) : sel_z;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) nb_sel <= '0;
    else if (cmd.acc_hi) nb_sel <= nb_sel + kidi_pkg::NB_IDX_W'(1);
  end

  // Weight times |z| in two halves, signed accumulate
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod <= kidi_pkg::PROD_W'(div_q[kidi_pkg::W_LO_W-1:0]) * kidi_pkg::PROD_W'(az);
    end else if (cmd.mul_hi) begin
      prod <= kidi_pkg::PROD_W'(div_q[kidi_pkg::W_W-1:kidi_pkg::W_LO_W]) *
              kidi_pkg::PROD_W'(az);
    end
  end

  always_comb begin
    addend = kidi_pkg::ACC_W'(prod);
    if (cmd.acc_hi) addend = addend << kidi_pkg::W_LO_W;
    if (sel_z[CW-1]) addend = -addend;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc   <= '0;
      total <= '0;
    end else begin
      if (cmd.acc_lo || cmd.acc_hi) acc <= acc + addend;
      if (cmd.acc_lo) total <= total + kidi_pkg::TOT_W'(div_q);
    end
  end

  always_comb begin
    acc_abs = acc[kidi_pkg::ACC_W-1] ? -acc : acc;
    mag     = acc_abs[kidi_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_f_start) res_neg <= acc[kidi_pkg::ACC_W-1];
  end

  // Shared divider: weights 2^48/(d2+s), then |sum|/total
  always_comb begin
    div_start = cmd.div_w_start || cmd.div_f_start;
    if (cmd.div_f_start) begin
      div_rem_init = kidi_pkg::DIV_W'(mag[kidi_pkg::MAG_W-1:CW]);
      div_sh_init  = {mag[CW-1:0], (kidi_pkg::SH_W - CW)'(0)};
      div_divisor  = kidi_pkg::DIV_W'(total);
      div_iters    = kidi_pkg::IT_W'(CW);
    end else begin
      div_rem_init = '0;
      div_sh_init  = kidi_pkg::SH_W'(1) << (kidi_pkg::SH_W - 1);
      div_divisor  = kidi_pkg::DIV_W'(sel_d2) + kidi_pkg::DIV_W'(smoothing);
      div_iters    = kidi_pkg::IT_W'(kidi_pkg::SH_W);
    end
  end

  kidi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .sh_init  (div_sh_init),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .busy     (div_busy),
    .quot     (div_q)
  );

  // Result value
  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      case (cmd.val_sel)
        kidi_pkg::VAL_HIT:  value <= nb_z[0];
        kidi_pkg::VAL_QUOT: value <= res_neg ? CW'(-div_q[CW-1:0]) : div_q[CW-1:0];
        default:            value <= '0;
      endcase
    end
  end

  // Status to controller
  always_comb begin
    stat.count_zero = (point_count == '0);
    stat.count_full = (point_count == kidi_pkg::CNT_W'(kidi_pkg::MAX_POINTS));
    stat.scan_busy  = issuing || s1_v || s2_v || s3_v || s4_v;
    stat.hit        = (nb_d2[0] < kidi_pkg::HIT_LIMIT);
    stat.div_busy   = div_busy;
    stat.last_nb    = (kidi_pkg::NB_CNT_W'(nb_sel) == nb_cnt - kidi_pkg::NB_CNT_W'(1));
    stat.total_zero = (total == '0);
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    point_count <= kidi_pkg::CNT_W'(kidi_pkg::MAX_POINTS))
    else $error("point count beyond store depth");

  a_nb_range: assert property (@(posedge clk) disable iff (rst)
    nb_cnt <= kidi_pkg::NB_CNT_W'(NB))
    else $error("neighbor count beyond list depth");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_scan_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.query_start |=> issuing)
    else $error("scan did not start");

endmodule
`default_nettype wire

/* hw/rtl/knn_inverse_distance_interpolator_core.sv */
`default_nettype none
// k-nearest inverse-distance interpolator over a store of up to 1024 points.
// Command channel: a transaction is taken on a clock edge with start high and
// busy low; opcode selects load point (0), clear store (1) or query (2, 3).
// Every transaction gives one result: done is high for one cycle with value
// and status valid; the receiver cannot stall, so results are never held.
// Load, clear and a query on an empty store answer in the cycle after they are
// taken and leave busy low, so the next transaction can follow at once.
// A query scans the store through one memory read port, tests for a
// coincident nearest point, then for each of up to 15 neighbors runs a serial
// divide for the weight plus its start, hand-off, multiply and accumulate steps,
// then the final divide.
// cfg_we writes the smoothing term from cfg_wdata; write only while idle.
// Synchronous reset empties the store and sets smoothing to 0.25.
module knn_inverse_distance_interpolator_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          opcode,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] pos_x,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] pos_y,
  input  wire logic signed [kidi_pkg::COORD_W-1:0] height,
  input  wire logic                                cfg_we,
  input  wire logic [kidi_pkg::SMOOTH_W-1:0]       cfg_wdata,
  output logic                                     done,
  output logic signed [kidi_pkg::COORD_W-1:0]      value,
  output logic [2:0]                               status
);

  kidi_pkg::kidi_cmd_t  cmd;
  kidi_pkg::kidi_stat_t stat;

  kidi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  kidi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .height    (height),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .value     (value)
  );

endmodule
`default_nettype wire
